FILE: rtl/pst_pkg.sv
// ----------------------------------------------------------------------------
// pst_pkg: shared types and constants of the scheduler tick block
// Task status codes, policy codes, datapath commands and status flags.
// ----------------------------------------------------------------------------
package pst_pkg;

  localparam int DEF_MAX_TASKS = 16;
  localparam int DEF_TIME_BITS = 16;
  localparam int FIELD_W       = 16;
  localparam int TASK_OUT_W    = 4;
  localparam int POLICY_W      = 2;

  localparam logic [POLICY_W-1:0] POL_FCFS = 2'd0;
  localparam logic [POLICY_W-1:0] POL_SRTF = 2'd1;
  localparam logic [POLICY_W-1:0] POL_RR   = 2'd2;

  localparam logic OP_CREATE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  typedef enum logic [1:0] {
    ST_PENDING = 2'd0,
    ST_READY   = 2'd1,
    ST_RUNNING = 2'd2,
    ST_DONE    = 2'd3
  } task_st_t;

  typedef enum logic [3:0] {
    DP_NONE,
    DP_CREATE,
    DP_CHG_RD,
    DP_CHG_WR,
    DP_ARR,
    DP_REQ,
    DP_SEL,
    DP_PICK,
    DP_SHIFT,
    DP_OUT
  } dp_op_t;

  typedef struct packed {
    logic   load;
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic arr_last;
    logic sel_skip;
    logic sel_last;
    logic shift_last;
  } dp_status_t;

endpackage

FILE: rtl/pst_ctrl.sv
// ----------------------------------------------------------------------------
// pst_ctrl: scheduler sequencer
// Steps one item through create, charge, arrival scan, requeue, selection
// scan, pick and ready-order compaction.
// ----------------------------------------------------------------------------
module pst_ctrl #(
  parameter int MAX_TASKS = pst_pkg::DEF_MAX_TASKS,
  parameter int SCNT_W    = $clog2(MAX_TASKS + 2)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                in_op,
  input  pst_pkg::dp_status_t status,
  output logic                busy,
  output pst_pkg::dp_cmd_t    cmd,
  output logic [SCNT_W-1:0]   idx
);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_CREATE = 10'b0000000010,
    S_CHG_RD = 10'b0000000100,
    S_CHG_WR = 10'b0000001000,
    S_ARR    = 10'b0000010000,
    S_REQ    = 10'b0000100000,
    S_SEL    = 10'b0001000000,
    S_PICK   = 10'b0010000000,
    S_SHIFT  = 10'b0100000000,
    S_OUT    = 10'b1000000000
  } state_t;

  state_t            state_r, state_nxt;
  logic [SCNT_W-1:0] idx_r, idx_nxt;
  logic              accept;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;
  assign idx    = idx_r;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cmd.load  = accept;
    cmd.op    = pst_pkg::DP_NONE;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = (in_op == pst_pkg::OP_CREATE) ? S_CREATE : S_CHG_RD;
        end
      end
      S_CREATE: begin
        cmd.op    = pst_pkg::DP_CREATE;
        state_nxt = S_OUT;
      end
      S_CHG_RD: begin
        cmd.op    = pst_pkg::DP_CHG_RD;
        state_nxt = S_CHG_WR;
      end
      S_CHG_WR: begin
        cmd.op    = pst_pkg::DP_CHG_WR;
        idx_nxt   = '0;
        state_nxt = S_ARR;
      end
      S_ARR: begin
        cmd.op  = pst_pkg::DP_ARR;
        idx_nxt = idx_r + 1'b1;
        if (status.arr_last) begin
          state_nxt = S_REQ;
        end
      end
      S_REQ: begin
        cmd.op    = pst_pkg::DP_REQ;
        idx_nxt   = '0;
        state_nxt = S_SEL;
      end
      S_SEL: begin
        cmd.op = pst_pkg::DP_SEL;
        if (status.sel_skip) begin
          state_nxt = S_OUT;
        end else begin
          idx_nxt = idx_r + 1'b1;
          if (status.sel_last) begin
            state_nxt = S_PICK;
          end
        end
      end
      S_PICK: begin
        cmd.op    = pst_pkg::DP_PICK;
        state_nxt = S_SHIFT;
      end
      S_SHIFT: begin
        cmd.op = pst_pkg::DP_SHIFT;
        if (status.shift_last) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        cmd.op    = pst_pkg::DP_OUT;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

FILE: rtl/pst_dpath.sv
// ----------------------------------------------------------------------------
// pst_dpath: scheduler datapath
// Task tables, ready order, counters, current task and result registers.
// ----------------------------------------------------------------------------
module pst_dpath #(
  parameter int MAX_TASKS = pst_pkg::DEF_MAX_TASKS,
  parameter int TIME_BITS = pst_pkg::DEF_TIME_BITS,
  parameter int SCNT_W    = $clog2(MAX_TASKS + 2)
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  pst_pkg::dp_cmd_t                    cmd,
  input  logic [SCNT_W-1:0]                   idx,
  input  logic [pst_pkg::FIELD_W-1:0]         in_start_time,
  input  logic [pst_pkg::FIELD_W-1:0]         in_required_time,
  input  logic [pst_pkg::FIELD_W-1:0]         in_now,
  input  logic                                cfg_wr_en,
  input  logic [pst_pkg::POLICY_W-1:0]        cfg_wr_data,
  output pst_pkg::dp_status_t                 status,
  output logic                                out_valid,
  output logic                                out_running_valid,
  output logic [pst_pkg::TASK_OUT_W-1:0]      out_running_task,
  output logic                                out_retired_valid,
  output logic [pst_pkg::TASK_OUT_W-1:0]      out_retired_task,
  output logic [pst_pkg::FIELD_W-1:0]         out_turnaround,
  output logic                                out_create_rejected
);

  localparam int IDX_W = $clog2(MAX_TASKS);
  localparam int FW    = pst_pkg::FIELD_W;
  localparam int TW    = pst_pkg::TASK_OUT_W;

  // memories
  logic [TIME_BITS-1:0] start_mem [MAX_TASKS];
  logic [TIME_BITS-1:0] req_mem   [MAX_TASKS];
  logic [TIME_BITS-1:0] exe_mem   [MAX_TASKS];
  pst_pkg::task_st_t    stat_mem  [MAX_TASKS];
  logic [IDX_W-1:0]     rdy_mem   [MAX_TASKS];

  logic [TIME_BITS-1:0] start_rd, req_rd, exe_rd;
  pst_pkg::task_st_t    stat_rd;
  logic [IDX_W-1:0]     rdy_rd;

  logic [IDX_W-1:0]     tab_ra, rdy_ra;
  logic                 tab_we, exe_we, stat_we, rdy_we;
  logic [IDX_W-1:0]     tab_wa, exe_wa, stat_wa, rdy_wa;
  logic [TIME_BITS-1:0] exe_wd;
  pst_pkg::task_st_t    stat_wd;
  logic [IDX_W-1:0]     rdy_wd;

  // control and payload registers
  logic [pst_pkg::POLICY_W-1:0] policy_r, policy_nxt;
  logic [SCNT_W-1:0]    cc_r, cc_nxt, rc_r, rc_nxt, sh_r, sh_nxt;
  logic                 cur_v_r, cur_v_nxt;
  logic [IDX_W-1:0]     cur_r, cur_nxt;
  logic                 arrived_r, arrived_nxt;
  logic                 arr_pv_r, arr_pv_nxt;
  logic [IDX_W-1:0]     arr_pt_r, arr_pt_nxt;
  logic                 p1_r, p1_nxt, p2_r, p2_nxt;
  logic [SCNT_W-1:0]    p1_pos_r, p1_pos_nxt, p2_pos_r, p2_pos_nxt;
  logic [IDX_W-1:0]     p2_task_r, p2_task_nxt;
  logic [SCNT_W-1:0]    best_pos_r, best_pos_nxt;
  logic [IDX_W-1:0]     best_task_r, best_task_nxt;
  logic [TIME_BITS-1:0] best_rem_r, best_rem_nxt, best_start_r, best_start_nxt;
  logic                 wpv_r, wpv_nxt;
  logic [IDX_W-1:0]     wpos_r, wpos_nxt;
  logic [TIME_BITS-1:0] lat_start_r, lat_req_r, now_r;
  logic                 ret_v_r, ret_v_nxt, rej_r, rej_nxt;
  logic [IDX_W-1:0]     ret_t_r, ret_t_nxt;
  logic [TIME_BITS-1:0] turn_r, turn_nxt;
  logic                 ov_r;
  logic                 orv_r, oret_v_r, orej_r;
  logic [TW-1:0]        ort_r, oret_t_r;
  logic [FW-1:0]        oturn_r;

  // width adaptation
  logic [TIME_BITS+FW-1:0] ext_start, ext_req, ext_now;
  logic [FW+TIME_BITS-1:0] ext_turn;
  logic [TW+IDX_W-1:0]     ext_cur, ext_ret;
  logic [TIME_BITS-1:0]    exe_inc, rem_b, turn_calc;
  logic [SCNT_W-1:0]       sh_p1, rc_p1;
  logic                    full_tab, rdy_room, arr_hit, keep, sh_issue, upd;

  assign ext_start = {{TIME_BITS{1'b0}}, in_start_time};
  assign ext_req   = {{TIME_BITS{1'b0}}, in_required_time};
  assign ext_now   = {{TIME_BITS{1'b0}}, in_now};
  assign ext_turn  = {{FW{1'b0}}, turn_r};
  assign ext_cur   = {{TW{1'b0}}, cur_r};
  assign ext_ret   = {{TW{1'b0}}, ret_t_r};

  assign exe_inc   = exe_rd + 1'b1;
  assign rem_b     = req_rd - exe_rd;
  assign turn_calc = now_r - start_rd;
  assign sh_p1     = sh_r + 1'b1;
  assign rc_p1     = rc_r + 1'b1;
  assign full_tab  = (cc_r == SCNT_W'(MAX_TASKS));
  assign rdy_room  = (rc_r < SCNT_W'(MAX_TASKS));
  assign arr_hit   = arr_pv_r && (stat_rd == pst_pkg::ST_PENDING) && (now_r >= start_rd);
  assign sh_issue  = (sh_r < rc_r);
  assign keep      = cur_v_r && ((policy_r == pst_pkg::POL_SRTF) ? !arrived_r
                                                                 : (policy_r != pst_pkg::POL_RR));

  always_comb begin
    if (p2_pos_r == '0) begin
      upd = 1'b1;
    end else if (policy_r == pst_pkg::POL_SRTF) begin
      upd = !(best_rem_r < rem_b);
    end else if (policy_r == pst_pkg::POL_RR) begin
      upd = 1'b0;
    end else begin
      upd = (start_rd < best_start_r);
    end
  end

  assign status.arr_last   = (idx == cc_r);
  assign status.sel_skip   = cur_v_r || (rc_r == '0);
  assign status.sel_last   = (idx == rc_p1);
  assign status.shift_last = !sh_issue;

  // read address selection
  always_comb begin
    case (cmd.op)
      pst_pkg::DP_CHG_RD: tab_ra = cur_r;
      pst_pkg::DP_SEL:    tab_ra = rdy_rd;
      default:            tab_ra = idx[IDX_W-1:0];
    endcase
    rdy_ra = (cmd.op == pst_pkg::DP_SHIFT) ? sh_p1[IDX_W-1:0] : idx[IDX_W-1:0];
  end

  always_comb begin
    policy_nxt     = cfg_wr_en ? cfg_wr_data : policy_r;
    cc_nxt         = cc_r;
    rc_nxt         = rc_r;
    sh_nxt         = sh_r;
    cur_v_nxt      = cur_v_r;
    cur_nxt        = cur_r;
    arrived_nxt    = arrived_r;
    arr_pv_nxt     = (cmd.op == pst_pkg::DP_ARR) && (idx < cc_r);
    arr_pt_nxt     = idx[IDX_W-1:0];
    p1_nxt         = (cmd.op == pst_pkg::DP_SEL) && !status.sel_skip && (idx < rc_r);
    p1_pos_nxt     = idx;
    p2_nxt         = (cmd.op == pst_pkg::DP_SEL) && p1_r;
    p2_pos_nxt     = p1_pos_r;
    p2_task_nxt    = rdy_rd;
    best_pos_nxt   = best_pos_r;
    best_task_nxt  = best_task_r;
    best_rem_nxt   = best_rem_r;
    best_start_nxt = best_start_r;
    wpv_nxt        = (cmd.op == pst_pkg::DP_SHIFT) && sh_issue;
    wpos_nxt       = sh_r[IDX_W-1:0];
    ret_v_nxt      = ret_v_r;
    ret_t_nxt      = ret_t_r;
    turn_nxt       = turn_r;
    rej_nxt        = rej_r;
    tab_we  = 1'b0;
    tab_wa  = cc_r[IDX_W-1:0];
    exe_we  = 1'b0;
    exe_wa  = cc_r[IDX_W-1:0];
    exe_wd  = '0;
    stat_we = 1'b0;
    stat_wa = cc_r[IDX_W-1:0];
    stat_wd = pst_pkg::ST_PENDING;
    rdy_we  = 1'b0;
    rdy_wa  = rc_r[IDX_W-1:0];
    rdy_wd  = arr_pt_r;

    if (cmd.load) begin
      ret_v_nxt   = 1'b0;
      ret_t_nxt   = '0;
      turn_nxt    = '0;
      rej_nxt     = 1'b0;
      arrived_nxt = 1'b0;
    end

    // compaction write follows its read in the next cycle
    if (wpv_r) begin
      rdy_we = 1'b1;
      rdy_wa = wpos_r;
      rdy_wd = rdy_rd;
    end

    case (cmd.op)
      pst_pkg::DP_CREATE: begin
        if (full_tab) begin
          rej_nxt = 1'b1;
        end else begin
          tab_we  = 1'b1;
          exe_we  = 1'b1;
          stat_we = 1'b1;
          cc_nxt  = cc_r + 1'b1;
        end
      end
      pst_pkg::DP_CHG_WR: begin
        if (cur_v_r) begin
          exe_we = 1'b1;
          exe_wa = cur_r;
          exe_wd = exe_inc;
          if (exe_inc == req_rd) begin
            stat_we   = 1'b1;
            stat_wa   = cur_r;
            stat_wd   = pst_pkg::ST_DONE;
            ret_v_nxt = 1'b1;
            ret_t_nxt = cur_r;
            turn_nxt  = turn_calc;
            cur_v_nxt = 1'b0;
          end
        end
      end
      pst_pkg::DP_ARR: begin
        if (arr_hit) begin
          arrived_nxt = 1'b1;
          if (rdy_room) begin
            rdy_we  = 1'b1;
            stat_we = 1'b1;
            stat_wa = arr_pt_r;
            stat_wd = pst_pkg::ST_READY;
            rc_nxt  = rc_p1;
          end
        end
      end
      pst_pkg::DP_REQ: begin
        if (cur_v_r && !keep) begin
          cur_v_nxt = 1'b0;
          if (rdy_room) begin
            rdy_we  = 1'b1;
            rdy_wd  = cur_r;
            stat_we = 1'b1;
            stat_wa = cur_r;
            stat_wd = pst_pkg::ST_READY;
            rc_nxt  = rc_p1;
          end
        end
      end
      pst_pkg::DP_SEL: begin
        if (p2_r && upd) begin
          best_pos_nxt   = p2_pos_r;
          best_task_nxt  = p2_task_r;
          best_rem_nxt   = rem_b;
          best_start_nxt = start_rd;
        end
      end
      pst_pkg::DP_PICK: begin
        cur_v_nxt = 1'b1;
        cur_nxt   = best_task_r;
        stat_we   = 1'b1;
        stat_wa   = best_task_r;
        stat_wd   = pst_pkg::ST_RUNNING;
        rc_nxt    = rc_r - 1'b1;
        sh_nxt    = best_pos_r;
      end
      pst_pkg::DP_SHIFT: begin
        if (sh_issue) begin
          sh_nxt = sh_p1;
        end
      end
      default: begin
      end
    endcase
  end

  // memories: one write and one registered read each
  always_ff @(posedge clk) begin
    if (tab_we) begin
      start_mem[tab_wa] <= lat_start_r;
      req_mem[tab_wa]   <= lat_req_r;
    end
    start_rd <= start_mem[tab_ra];
    req_rd   <= req_mem[tab_ra];
  end

  always_ff @(posedge clk) begin
    if (exe_we) begin
      exe_mem[exe_wa] <= exe_wd;
    end
    exe_rd <= exe_mem[tab_ra];
  end

  always_ff @(posedge clk) begin
    if (stat_we) begin
      stat_mem[stat_wa] <= stat_wd;
    end
    stat_rd <= stat_mem[tab_ra];
  end

  always_ff @(posedge clk) begin
    if (rdy_we) begin
      rdy_mem[rdy_wa] <= rdy_wd;
    end
    rdy_rd <= rdy_mem[rdy_ra];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r  <= pst_pkg::POL_FCFS;
      cc_r      <= '0;
      rc_r      <= '0;
      sh_r      <= '0;
      cur_v_r   <= 1'b0;
      arr_pv_r  <= 1'b0;
      p1_r      <= 1'b0;
      p2_r      <= 1'b0;
      wpv_r     <= 1'b0;
      ov_r      <= 1'b0;
    end else begin
      policy_r  <= policy_nxt;
      cc_r      <= cc_nxt;
      rc_r      <= rc_nxt;
      sh_r      <= sh_nxt;
      cur_v_r   <= cur_v_nxt;
      arr_pv_r  <= arr_pv_nxt;
      p1_r      <= p1_nxt;
      p2_r      <= p2_nxt;
      wpv_r     <= wpv_nxt;
      ov_r      <= (cmd.op == pst_pkg::DP_OUT);
    end
  end

  // payload
  always_ff @(posedge clk) begin
    cur_r        <= cur_nxt;
    arrived_r    <= arrived_nxt;
    arr_pt_r     <= arr_pt_nxt;
    p1_pos_r     <= p1_pos_nxt;
    p2_pos_r     <= p2_pos_nxt;
    p2_task_r    <= p2_task_nxt;
    best_pos_r   <= best_pos_nxt;
    best_task_r  <= best_task_nxt;
    best_rem_r   <= best_rem_nxt;
    best_start_r <= best_start_nxt;
    wpos_r       <= wpos_nxt;
    ret_v_r      <= ret_v_nxt;
    ret_t_r      <= ret_t_nxt;
    turn_r       <= turn_nxt;
    rej_r        <= rej_nxt;
    if (cmd.load) begin
      lat_start_r <= ext_start[TIME_BITS-1:0];
      lat_req_r   <= ext_req[TIME_BITS-1:0];
      now_r       <= ext_now[TIME_BITS-1:0];
    end
    if (cmd.op == pst_pkg::DP_OUT) begin
      orv_r    <= cur_v_r;
      ort_r    <= cur_v_r ? ext_cur[TW-1:0] : '0;
      oret_v_r <= ret_v_r;
      oret_t_r <= ext_ret[TW-1:0];
      oturn_r  <= ext_turn[FW-1:0];
      orej_r   <= rej_r;
    end
  end

  assign out_valid           = ov_r;
  assign out_running_valid   = orv_r;
  assign out_running_task    = ort_r;
  assign out_retired_valid   = oret_v_r;
  assign out_retired_task    = oret_t_r;
  assign out_turnaround      = oturn_r;
  assign out_create_rejected = orej_r;

endmodule

FILE: rtl/process_scheduler_tick.sv
// ----------------------------------------------------------------------------
// process_scheduler_tick: task table scheduler, one create or tick per command
// Holds up to MAX_TASKS tasks, a ready order and the running task; a tick
// charges, retires, admits arrivals and picks the next task by policy.
// ----------------------------------------------------------------------------
// Usage: raise start with in_op and its fields; the command is taken when busy
// is low and busy stays high until the result beat is out. Each command gives
// exactly one result beat, shown for one cycle with out_valid; the receiver
// cannot stall it, so sample it then. A tick charges the running task, scans
// every created task for arrivals, requeues it if not kept, scans the ready
// order, picks a task and shifts the entries behind it to close the gap; when
// the running task is kept or nothing is ready, selection is skipped. The task
// table and the ready order each have a single read port, and the arrival scan
// and selection scan walk them one entry a cycle. Write cfg_wr_data (policy:
// 0 FCFS, 1 SRTF, 2 round robin, 3 as FCFS) only while busy is low. No
// clearing pass follows reset.
module process_scheduler_tick #(
  parameter int MAX_TASKS = pst_pkg::DEF_MAX_TASKS,
  parameter int TIME_BITS = pst_pkg::DEF_TIME_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_op,
  input  logic [pst_pkg::FIELD_W-1:0]         in_start_time,
  input  logic [pst_pkg::FIELD_W-1:0]         in_required_time,
  input  logic [pst_pkg::FIELD_W-1:0]         in_now,
  output logic                                out_valid,
  output logic                                out_running_valid,
  output logic [pst_pkg::TASK_OUT_W-1:0]      out_running_task,
  output logic                                out_retired_valid,
  output logic [pst_pkg::TASK_OUT_W-1:0]      out_retired_task,
  output logic [pst_pkg::FIELD_W-1:0]         out_turnaround,
  output logic                                out_create_rejected,
  input  logic                                cfg_wr_en,
  input  logic [pst_pkg::POLICY_W-1:0]        cfg_wr_data
);

  // scan counters must reach the ready count plus the two-stage read latency
  localparam int SCNT_W = $clog2(MAX_TASKS + 2);

  pst_pkg::dp_cmd_t    cmd;
  pst_pkg::dp_status_t status;
  logic [SCNT_W-1:0]   idx;

  // sequencer: owns the state and the scan index
  pst_ctrl #(
    .MAX_TASKS (MAX_TASKS),
    .SCNT_W    (SCNT_W)
  ) u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_op  (in_op),
    .status (status),
    .busy   (busy),
    .cmd    (cmd),
    .idx    (idx)
  );

  // datapath: tables, ready order, current task and the result beat
  pst_dpath #(
    .MAX_TASKS (MAX_TASKS),
    .TIME_BITS (TIME_BITS),
    .SCNT_W    (SCNT_W)
  ) u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .idx                 (idx),
    .in_start_time       (in_start_time),
    .in_required_time    (in_required_time),
    .in_now              (in_now),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .status              (status),
    .out_valid           (out_valid),
    .out_running_valid   (out_running_valid),
    .out_running_task    (out_running_task),
    .out_retired_valid   (out_retired_valid),
    .out_retired_task    (out_retired_task),
    .out_turnaround      (out_turnaround),
    .out_create_rejected (out_create_rejected)
  );

endmodule

FILE: rtl/pst_checker.sv
// ----------------------------------------------------------------------------
// pst_checker: port-level checks of the scheduler tick block
// Watches the command handshake and the result beat.
// ----------------------------------------------------------------------------
module pst_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               start,
  input logic                               busy,
  input logic                               out_valid,
  input logic                               out_running_valid,
  input logic [pst_pkg::TASK_OUT_W-1:0]     out_running_task,
  input logic                               out_retired_valid,
  input logic                               out_create_rejected
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted command did not raise busy");

  a_beat_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result beat longer than one cycle");

  a_beat_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result beat while busy");

  a_reject_no_retire: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_create_rejected |-> !out_retired_valid)
    else $error("reject and retire in one beat");

  a_idle_task_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_running_valid |-> out_running_task == '0)
    else $error("running task nonzero with none running");

endmodule

bind process_scheduler_tick pst_checker u_pst_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .start               (start),
  .busy                (busy),
  .out_valid           (out_valid),
  .out_running_valid   (out_running_valid),
  .out_running_task    (out_running_task),
  .out_retired_valid   (out_retired_valid),
  .out_create_rejected (out_create_rejected)
);

FILE: test/process_scheduler_tick_test.sv
// ----------------------------------------------------------------------------
// process_scheduler_tick_test: self-checking bench for the scheduler tick block
// Drives create and tick commands under every policy and several idle
// patterns; a scoreboard predicts each result beat and compares it field by
// field with what the block shows on out_valid.
// ----------------------------------------------------------------------------
class sched_board;
  typedef struct packed {
    logic        run_v;
    logic [3:0]  run_t;
    logic        ret_v;
    logic [3:0]  ret_t;
    logic [15:0] turn;
    logic        rej;
  } beat_t;

  logic [1:0]         policy;
  logic [15:0]        t_start [16];
  logic [15:0]        t_req   [16];
  logic [15:0]        t_exec  [16];
  pst_pkg::task_st_t  t_stat  [16];
  int                 n_created;
  logic [3:0]         rdy [16];
  int                 n_ready;
  logic [3:0]         cur;
  logic               cur_v;
  beat_t              pending_beats [$];
  int                 errors;
  int                 n_ticks, n_creates, n_retired, n_rejected;

  function new();
    policy = pst_pkg::POL_FCFS;
    n_created = 0;
    n_ready = 0;
    cur = '0;
    cur_v = 1'b0;
    errors = 0;
    n_ticks = 0; n_creates = 0; n_retired = 0; n_rejected = 0;
    foreach (t_stat[i]) t_stat[i] = pst_pkg::ST_PENDING;
  endfunction

  function void report(string what, logic [15:0] got, logic [15:0] want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endfunction

  function logic [15:0] left_of(logic [3:0] t);
    return t_req[t] - t_exec[t];
  endfunction

  function void enqueue(logic [3:0] t);
    if (n_ready < 16) begin
      rdy[n_ready] = t;
      n_ready++;
      t_stat[t] = pst_pkg::ST_READY;
    end
  endfunction

  // Predict the beat caused by one accepted command.
  function void note(logic op, logic [15:0] st, logic [15:0] rq, logic [15:0] nw);
    beat_t b;
    logic arrived, keep;
    logic [3:0] a, c;
    int sel;
    b = '0;
    arrived = 1'b0;
    keep = 1'b0;
    if (op == pst_pkg::OP_CREATE) begin
      n_creates++;
      if (n_created >= 16) begin
        b.rej = 1'b1;
        n_rejected++;
      end else begin
        t_start[n_created] = st;
        t_req[n_created] = rq;
        t_exec[n_created] = '0;
        t_stat[n_created] = pst_pkg::ST_PENDING;
        n_created++;
      end
    end else begin
      n_ticks++;
      if (cur_v) begin
        t_exec[cur] = t_exec[cur] + 16'd1;
        if (t_exec[cur] == t_req[cur]) begin
          t_stat[cur] = pst_pkg::ST_DONE;
          b.ret_v = 1'b1;
          b.ret_t = cur;
          b.turn = nw - t_start[cur];
          cur_v = 1'b0;
          n_retired++;
        end
      end
      for (int t = 0; t < n_created; t++) begin
        if (t_stat[t] == pst_pkg::ST_PENDING && nw >= t_start[t]) begin
          enqueue(4'(t));
          arrived = 1'b1;
        end
      end
      if (cur_v) begin
        if (policy == pst_pkg::POL_SRTF) keep = !arrived;
        else if (policy != pst_pkg::POL_RR) keep = 1'b1;
        if (!keep) begin
          enqueue(cur);
          cur_v = 1'b0;
        end
      end
      if (!keep && n_ready > 0) begin
        sel = 0;
        for (int k = 0; k < n_ready; k++) begin
          a = rdy[sel];
          c = rdy[k];
          if (policy == pst_pkg::POL_SRTF) begin
            if (!(left_of(a) < left_of(c))) sel = k;
          end else if (policy != pst_pkg::POL_RR) begin
            if (!(t_start[a] <= t_start[c])) sel = k;
          end
        end
        cur = rdy[sel];
        cur_v = 1'b1;
        t_stat[cur] = pst_pkg::ST_RUNNING;
        for (int k = sel; k + 1 < n_ready; k++) rdy[k] = rdy[k+1];
        n_ready--;
      end
    end
    b.run_v = cur_v;
    b.run_t = cur_v ? cur : 4'd0;
    pending_beats.push_back(b);
  endfunction

  function void check(beat_t got);
    beat_t w;
    if (pending_beats.size() == 0) begin
      $display("MISMATCH unexpected result beat at %0t", $realtime);
      errors++;
      return;
    end
    w = pending_beats.pop_front();
    if (got.run_v !== w.run_v) report("running_valid", got.run_v, w.run_v);
    if (got.run_t !== w.run_t) report("running_task", got.run_t, w.run_t);
    if (got.ret_v !== w.ret_v) report("retired_valid", got.ret_v, w.ret_v);
    if (got.ret_t !== w.ret_t) report("retired_task", got.ret_t, w.ret_t);
    if (got.turn !== w.turn) report("turnaround", got.turn, w.turn);
    if (got.rej !== w.rej) report("create_rejected", got.rej, w.rej);
  endfunction
endclass

module process_scheduler_tick_test;
  localparam logic [pst_pkg::POLICY_W-1:0] POL_SPARE = 2'd3;  // unassigned code, acts as FCFS
  localparam int STALL_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_op = pst_pkg::OP_CREATE;
  logic [15:0] in_start_time = '0;
  logic [15:0] in_required_time = 16'd1;
  logic [15:0] in_now = '0;
  logic        out_valid;
  logic        out_running_valid;
  logic [3:0]  out_running_task;
  logic        out_retired_valid;
  logic [3:0]  out_retired_task;
  logic [15:0] out_turnaround;
  logic        out_create_rejected;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_wr_data = '0;

  sched_board board = new();
  int          idle_pct;       // chance in a hundred that the sender idles
  logic [15:0] clock_now;      // running time stamp carried by ticks
  int          stall_cycles;

  process_scheduler_tick dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_op(in_op), .in_start_time(in_start_time),
    .in_required_time(in_required_time), .in_now(in_now),
    .out_valid(out_valid), .out_running_valid(out_running_valid),
    .out_running_task(out_running_task), .out_retired_valid(out_retired_valid),
    .out_retired_task(out_retired_task), .out_turnaround(out_turnaround),
    .out_create_rejected(out_create_rejected),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Monitor: check result beats against the oldest prediction, then note a
  // newly accepted command. Both see pre-edge values, so order is safe.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid)
        board.check({out_running_valid, out_running_task, out_retired_valid,
                     out_retired_task, out_turnaround, out_create_rejected});
      if (start && !busy)
        board.note(in_op, in_start_time, in_required_time, in_now);
    end
  end

  // Watchdog: count cycles in which no beat moves either way.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("process_scheduler_tick_test NOT OK");
        $finish;
      end
    end
  end

  // Present one command, hold it until taken, then maybe idle the sender.
  task automatic send_cmd(logic op, logic [15:0] st, logic [15:0] rq, logic [15:0] nw);
    in_op <= op;
    in_start_time <= st;
    in_required_time <= rq;
    in_now <= nw;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  // Drop start and hold until every predicted beat has come back.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (board.pending_beats.size() != 0 || busy);
  endtask

  task automatic set_policy(logic [1:0] pol);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= pol;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    board.policy = pol;
  endtask

  task automatic send_tick();
    logic [15:0] nw;
    // Advance time slowly so tasks arrive and run; jump now and then.
    if ($urandom_range(99) < 4) clock_now = 16'($urandom_range(65535));
    else clock_now = clock_now + 16'($urandom_range(2));
    nw = clock_now;
    send_cmd(pst_pkg::OP_TICK, 16'($urandom_range(65535)), 16'($urandom_range(65535)), nw);
  endtask

  task automatic send_create();
    logic [15:0] st, rq;
    if ($urandom_range(9) == 0) st = 16'($urandom_range(65535));
    else st = clock_now + 16'($urandom_range(8));
    if ($urandom_range(9) == 0) rq = 16'($urandom_range(65535, 1));
    else rq = 16'($urandom_range(12, 1));
    send_cmd(pst_pkg::OP_CREATE, st, rq, 16'($urandom_range(65535)));
  endtask

  initial begin
    logic [1:0] pol_seq [8] = '{pst_pkg::POL_FCFS, pst_pkg::POL_SRTF, pst_pkg::POL_RR,
                               POL_SPARE, pst_pkg::POL_SRTF, pst_pkg::POL_RR,
                               pst_pkg::POL_FCFS, POL_SPARE};
    int idle_seq [4] = '{0, 74, 22, 0};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    idle_pct = 0;
    clock_now = '0;

    // Directed: tasks at the time extremes, a retire, and the time wrap.
    set_policy(pst_pkg::POL_FCFS);
    send_cmd(pst_pkg::OP_CREATE, 16'd0, 16'd1, 16'hFFFF);
    send_cmd(pst_pkg::OP_CREATE, 16'hFFFF, 16'd3, 16'd0);
    send_cmd(pst_pkg::OP_TICK, 16'hFFFF, 16'hFFFF, 16'd0);
    send_cmd(pst_pkg::OP_TICK, 16'd0, 16'd0, 16'd1);
    send_cmd(pst_pkg::OP_TICK, 16'd0, 16'd0, 16'hFFFF);
    send_cmd(pst_pkg::OP_TICK, 16'd0, 16'd0, 16'hFFFF);
    send_cmd(pst_pkg::OP_TICK, 16'd0, 16'd0, 16'd0);
    send_cmd(pst_pkg::OP_TICK, 16'd0, 16'd0, 16'd2);
    send_cmd(pst_pkg::OP_TICK, 16'd0, 16'd0, 16'd3);

    // Random phases: each adds a couple of tasks, then mostly ticks. Once the
    // table is full the stray creates check the rejection path.
    foreach (pol_seq[p]) begin
      set_policy(pol_seq[p]);
      idle_pct = idle_seq[p % 4];
      for (int i = 0; i < 118; i++) begin
        if (i < 2 || $urandom_range(99) < 6) send_create();
        else send_tick();
        if (p == 2 && i == 60) drain();
      end
    end

    drain();
    repeat (100) @(posedge clk);
    $display("Covered %0d ticks and %0d creates (%0d rejected), %0d tasks retired",
             board.n_ticks, board.n_creates, board.n_rejected, board.n_retired);
    $display("across all four policy codes with sender idle phases of 0, 22 and 74 percent");
    if (board.errors == 0 && board.pending_beats.size() == 0) begin
      $display("process_scheduler_tick_test OK");
    end else begin
      $display("process_scheduler_tick_test NOT OK");
    end
    $finish;
  end
endmodule

FILE: files.f
rtl/pst_pkg.sv
rtl/pst_ctrl.sv
rtl/pst_dpath.sv
rtl/process_scheduler_tick.sv
rtl/pst_checker.sv
test/process_scheduler_tick_test.sv
